// ===== rtl/tmcs_pkg.sv =====
// ---------------------------------------------------------------------------
// Texture mip chain size package
// Format table, limits and sequencer states shared by the size calculator.
// ---------------------------------------------------------------------------
package tmcs_pkg;

   localparam int FORMAT_COUNT   = 79;
   localparam int MAX_MIP_LEVELS = 15;

   localparam int CODE_W  = 7;
   localparam int EXT_W   = 15;
   localparam int LVL_W   = 4;
   localparam int LAYER_W = 12;
   localparam int SIZE_W  = 5;
   localparam int TOTAL_W = 64;
   localparam int MUL_W   = 32;

   localparam logic [CODE_W-1:0] FIRST_COMPRESSED = 7'd51;
   localparam logic [CODE_W-1:0] LAST_COMPRESSED  = 7'd78;
   localparam logic [CODE_W-1:0] ASTC8_FIRST      = 7'd69;
   localparam logic [CODE_W-1:0] ASTC8_LAST       = 7'd70;

   localparam logic [LVL_W-1:0] MAX_LEVELS = LVL_W'(MAX_MIP_LEVELS);

   // Bytes per pixel, or per block for the compressed codes.
   localparam logic [SIZE_W-1:0] UNIT_BYTES [FORMAT_COUNT] = '{
      5'd0,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd2,  5'd2,  5'd2,  5'd2,
      5'd2,  5'd2,  5'd2,  5'd2,  5'd2,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4,
      5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4,
      5'd4,  5'd4,  5'd4,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,
      5'd8,  5'd12, 5'd12, 5'd12, 5'd16, 5'd16, 5'd16, 5'd2,  5'd4,  5'd4,
      5'd5,
      5'd8,  5'd8,  5'd8,  5'd8,  5'd16, 5'd16, 5'd16, 5'd16, 5'd8,  5'd8,
      5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16,
      5'd16, 5'd16, 5'd16, 5'd16,
      5'd8,  5'd8,  5'd16, 5'd16, 5'd8,  5'd8,  5'd16, 5'd16
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_LV_DL,
      ST_LV_XY,
      ST_LV_COST,
      ST_FINISH,
      ST_RESULT
   } state_type;

   function automatic logic [SIZE_W-1:0] unit_size(input logic [CODE_W-1:0] code);
      logic [SIZE_W-1:0] s;
      s = '0;
      if (int'(code) < FORMAT_COUNT) begin
         s = UNIT_BYTES[code];
      end
      return s;
   endfunction

   function automatic logic [EXT_W-1:0] halve_floor1(input logic [EXT_W-1:0] v);
      logic [EXT_W-1:0] h;
      h = v >> 1;
      if (h == '0) begin
         h = EXT_W'(1);
      end
      return h;
   endfunction

endpackage

// ===== rtl/texture_mip_chain_size.sv =====
// ---------------------------------------------------------------------------
// Texture mip chain size
// Sums the byte size of every mip level and array layer of one texture.
// ---------------------------------------------------------------------------
// A request passes through setup, then the level loop once per mip level
// (the level count is saturated to 15), then a final sum before the result
// is offered; a texture with a zero extent, zero layers, zero levels or an
// unknown format skips the level loop. A single 32x32 multiplier is shared
// by every product: once per request for the unit size times the layer
// count, then three times per level (depth times that, the block or pixel
// count, and the level cost). The block accepts no request until the
// result has been taken, and is ready again the cycle after.
module texture_mip_chain_size (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tmcs_pkg::CODE_W-1:0]   req_format_code,
   input  logic [tmcs_pkg::EXT_W-1:0]    req_width,
   input  logic [tmcs_pkg::EXT_W-1:0]    req_height,
   input  logic [tmcs_pkg::EXT_W-1:0]    req_depth,
   input  logic [tmcs_pkg::LVL_W-1:0]    req_mip_levels,
   input  logic [tmcs_pkg::LAYER_W-1:0]  req_layer_count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tmcs_pkg::TOTAL_W-1:0]  rsp_total_bytes
);
   import tmcs_pkg::*;

   localparam int SL_W = SIZE_W + LAYER_W;   // size * layers
   localparam int DL_W = EXT_W + SL_W;       // depth * size * layers
   localparam int XY_W = 2 * EXT_W;          // blocks or pixels in a level

   state_type state_ff, state_in;

   logic [EXT_W-1:0]   w_ff, h_ff, d_ff;
   logic [LVL_W-1:0]   levels_ff;
   logic [LAYER_W-1:0] layers_ff;
   logic [SIZE_W-1:0]  size_ff;
   logic               comp_ff;
   logic               big_blk_ff;
   logic [SL_W-1:0]    sl_ff;
   logic [DL_W-1:0]    dl_ff;
   logic [XY_W-1:0]    xy_ff;
   logic [TOTAL_W-1:0] prod_ff;
   logic [TOTAL_W-1:0] acc_ff;

   logic [MUL_W-1:0]   mul_a, mul_b;
   logic [TOTAL_W-1:0] mul_p;
   logic [EXT_W:0]     w_round, h_round;
   logic [EXT_W-1:0]   bx, by;
   logic               skip;
   logic               accept;

   assign accept = req_valid && req_ready;

   // Nothing to sum: any zero factor gives an empty chain.
   assign skip = (w_ff == '0) || (h_ff == '0) || (d_ff == '0) || (levels_ff == '0)
              || (layers_ff == '0) || (size_ff == '0);

   // Blocks across and down: round up to 4 or 8, or plain pixels.
   always_comb begin
      w_round = {1'b0, w_ff};
      h_round = {1'b0, h_ff};
      bx      = w_ff;
      by      = h_ff;
      if (comp_ff) begin
         if (big_blk_ff) begin
            w_round = {1'b0, w_ff} + (EXT_W+1)'(7);
            h_round = {1'b0, h_ff} + (EXT_W+1)'(7);
            bx      = EXT_W'(w_round >> 3);
            by      = EXT_W'(h_round >> 3);
         end else begin
            w_round = {1'b0, w_ff} + (EXT_W+1)'(3);
            h_round = {1'b0, h_ff} + (EXT_W+1)'(3);
            bx      = EXT_W'(w_round >> 2);
            by      = EXT_W'(h_round >> 2);
         end
      end
   end

   // Shared multiplier: select operands for the current step.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SETUP: begin
            mul_a = MUL_W'(size_ff);
            mul_b = MUL_W'(layers_ff);
         end
         ST_LV_DL: begin
            mul_a = MUL_W'(d_ff);
            mul_b = MUL_W'(sl_ff);
         end
         ST_LV_XY: begin
            mul_a = MUL_W'(bx);
            mul_b = MUL_W'(by);
         end
         ST_LV_COST: begin
            mul_a = MUL_W'(xy_ff);
            mul_b = MUL_W'(dl_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = TOTAL_W'(mul_a) * TOTAL_W'(mul_b);

   // Sequencer: next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            state_in = skip ? ST_FINISH : ST_LV_DL;
         end
         ST_LV_DL: begin
            state_in = ST_LV_XY;
         end
         ST_LV_XY: begin
            state_in = ST_LV_COST;
         end
         ST_LV_COST: begin
            state_in = (levels_ff == LVL_W'(1)) ? ST_FINISH : ST_LV_DL;
         end
         ST_FINISH: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer: handshake outputs.
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_RESULT);
   end

   assign rsp_total_bytes = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               w_ff       <= req_width;
               h_ff       <= req_height;
               d_ff       <= req_depth;
               levels_ff  <= (req_mip_levels > MAX_LEVELS) ? MAX_LEVELS : req_mip_levels;
               layers_ff  <= req_layer_count;
               size_ff    <= unit_size(req_format_code);
               comp_ff    <= (req_format_code >= FIRST_COMPRESSED)
                          && (req_format_code <= LAST_COMPRESSED);
               big_blk_ff <= (req_format_code >= ASTC8_FIRST)
                          && (req_format_code <= ASTC8_LAST);
               acc_ff     <= '0;
            end
         end
         ST_SETUP: begin
            sl_ff   <= SL_W'(mul_p);
            prod_ff <= '0;
         end
         ST_LV_DL: begin
            // Fold in the previous level's cost while the next one starts.
            dl_ff  <= DL_W'(mul_p);
            acc_ff <= acc_ff + prod_ff;
         end
         ST_LV_XY: begin
            xy_ff <= XY_W'(mul_p);
         end
         ST_LV_COST: begin
            prod_ff   <= mul_p;
            w_ff      <= halve_floor1(w_ff);
            h_ff      <= halve_floor1(h_ff);
            d_ff      <= halve_floor1(d_ff);
            levels_ff <= levels_ff - LVL_W'(1);
         end
         ST_FINISH: begin
            acc_ff <= acc_ff + prod_ff;
         end
         default: begin
            // Hold the result until it is taken.
         end
      endcase
   end

endmodule
